@@ rtl/rrtt_pkg.sv @@
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants for the round-robin task table: command and
// status codes, request/response words, and the controller/datapath link.
// ----------------------------------------------------------------------------
package rrtt_pkg;

   // Command codes carried in the request word
   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_CREATE   = 2'd1,
      CMD_EXIT     = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   // Status codes carried in the response word
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SLOT    = 2'd1,
      ST_ALLOC_FAIL = 2'd2,
      ST_UNUSED     = 2'd3
   } stat_type;

   // Saved frame sizes
   localparam int unsigned KERNEL_FRAME_WORDS = 15;
   localparam int unsigned USER_FRAME_WORDS   = 17;
   localparam int unsigned WORD_BYTES         = 4;
   localparam logic [31:0] KERNEL_FRAME_BYTES = 32'(KERNEL_FRAME_WORDS * WORD_BYTES);
   localparam logic [31:0] USER_FRAME_BYTES   = 32'(USER_FRAME_WORDS * WORD_BYTES);

   // Request word
   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        saved_sp;
      logic [31:0]        stack_addr;
      logic [31:0]        dir_addr;
      logic               user_task;
      logic signed [31:0] exit_code;
   } req_type;

   // Response word
   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         slot;
      logic [31:0]        resume_sp;
      logic               switched;
      logic [31:0]        next_dir;
      logic [31:0]        kernel_stack_top;
      logic [31:0]        release_stack;
      logic [31:0]        release_dir;
      logic               others_ready;
      logic signed [31:0] recorded_code;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic step;
      logic finish;
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    hit;
      logic    switch_req;
   } sts_type;

endpackage

@@ rtl/rrtt_ram.sv @@
// ----------------------------------------------------------------------------
// rrtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rrtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Sequencer for the task table: accepts a command, steps the slot scan,
// waits out the table read and strobes the response.
// ----------------------------------------------------------------------------
module rrtt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        command,
   input  rrtt_pkg::sts_type sts,
   output rrtt_pkg::ctl_type ctl,
   output logic              busy,
   output logic              rsp_strobe
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;
   logic      strobe_in;

   // Commands to the datapath
   always_comb begin
      ctl.capture = (state_ff == S_IDLE) && start;
      ctl.step    = (state_ff == S_SCAN) && !sts.hit;
      ctl.finish  = (state_ff == S_FINISH);
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (rrtt_pkg::cmd_type'(command))
                  rrtt_pkg::CMD_SCHEDULE: state_in = S_SCAN;
                  rrtt_pkg::CMD_CREATE:   state_in = S_SCAN;
                  rrtt_pkg::CMD_EXIT:     state_in = S_READ;
                  rrtt_pkg::CMD_NONE:     state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               if (sts.cmd == rrtt_pkg::CMD_SCHEDULE && sts.switch_req) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
         end
      endcase
   end

   // State and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

@@ rtl/rrtt_dpath.sv @@
// ----------------------------------------------------------------------------
// rrtt_dpath
// Task table datapath: slot flags, scan pointer, stack pointer and context
// RAMs, and the response register.
// ----------------------------------------------------------------------------
module rrtt_dpath #(
   parameter int SLOTS       = 8,
   parameter int STACK_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   input  rrtt_pkg::req_type req_word,
   input  rrtt_pkg::ctl_type ctl,
   output rrtt_pkg::sts_type sts,
   output rrtt_pkg::rsp_type rsp_word
);

   localparam int SW  = $clog2(SLOTS);
   localparam int HW  = $clog2(SLOTS + 1);
   localparam int HW1 = HW + 1;
   localparam int SW3 = SW + 3;
   localparam logic [31:0] STACK_SPAN = 32'(STACK_BYTES);

   // Round-robin increment below the high-water mark
   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] idx,
                                              input logic [HW-1:0] lim);
      logic [HW:0] nx;
      nx = HW1'(idx) + 1'b1;
      if (nx == HW1'(lim)) begin
         return '0;
      end
      return nx[SW-1:0];
   endfunction

   // Slot index as the 3-bit response field
   function automatic logic [2:0] slot3(input logic [SW-1:0] idx);
      logic [SW+2:0] w;
      w = SW3'(idx);
      return w[2:0];
   endfunction

   // Control state
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [HW-1:0]      cnt_ff, cnt_in;
   logic [SW-1:0]      run_ff, run_in;
   logic [HW-1:0]      hw_ff, hw_in;
   logic               boot_ff, boot_in;
   logic signed [31:0] last_ff, last_in;
   logic [31:0]        kdir_ff;

   // Payload
   rrtt_pkg::req_type  req_ff;
   rrtt_pkg::rsp_type  rsp_ff, rsp_in;
   logic [SW-1:0]      ptr_ff, ptr_in;
   logic [31:0]        top_ff;

   // Table RAM ports
   logic               sp_we;
   logic [SW-1:0]      sp_waddr;
   logic [31:0]        sp_wdata;
   logic [31:0]        sp_rd;
   logic               ctx_we;
   logic [63:0]        ctx_rd;
   logic [SW-1:0]      rd_addr;

   rrtt_pkg::cmd_type  cmd;
   rrtt_pkg::cmd_type  new_cmd;
   logic               boot_sel;
   logic [31:0]        eff_stack;
   logic [31:0]        eff_dir;
   logic [31:0]        frame;
   logic [31:0]        new_sp;
   logic               create_ok;

   assign cmd     = rrtt_pkg::cmd_type'(req_ff.command);
   assign new_cmd = rrtt_pkg::cmd_type'(req_word.command);

   // Status to the controller
   always_comb begin
      sts.cmd        = cmd;
      sts.switch_req = (ptr_ff != run_ff);
      if (cmd == rrtt_pkg::CMD_SCHEDULE) begin
         sts.hit = used_ff[ptr_ff] || (ptr_ff == run_ff);
      end else begin
         sts.hit = !used_ff[ptr_ff] || (ptr_ff == SW'(SLOTS - 1));
      end
   end

   // Scan pointer: next slot after the running one, or slot zero for create
   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.capture) begin
         ptr_in = (new_cmd == rrtt_pkg::CMD_SCHEDULE) ? wrap_inc(run_ff, hw_ff) : '0;
      end else if (ctl.step) begin
         ptr_in = (cmd == rrtt_pkg::CMD_SCHEDULE) ? wrap_inc(ptr_ff, hw_ff)
                                                  : ptr_ff + 1'b1;
      end
   end

   // Table read: exit reads the running slot, schedule the chosen one
   assign rd_addr = (cmd == rrtt_pkg::CMD_EXIT) ? run_ff : ptr_ff;

   // Boot task in slot zero has no stack and follows the kernel directory
   always_comb begin
      boot_sel  = boot_ff && (rd_addr == '0);
      eff_stack = boot_sel ? 32'd0 : ctx_rd[63:32];
      eff_dir   = boot_sel ? kdir_ff : ctx_rd[31:0];
      frame     = req_ff.user_task ? rrtt_pkg::USER_FRAME_BYTES
                                   : rrtt_pkg::KERNEL_FRAME_BYTES;
      new_sp    = top_ff - frame;
   end

   // Command completion
   always_comb begin
      used_in   = used_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      hw_in     = hw_ff;
      boot_in   = boot_ff;
      last_in   = last_ff;
      rsp_in    = '0;
      create_ok = 1'b0;
      unique case (cmd)
         rrtt_pkg::CMD_SCHEDULE: begin
            run_in           = ptr_ff;
            rsp_in.slot      = slot3(ptr_ff);
            if (ptr_ff != run_ff) begin
               rsp_in.switched         = 1'b1;
               rsp_in.resume_sp        = sp_rd;
               rsp_in.next_dir         = eff_dir;
               rsp_in.kernel_stack_top = (eff_stack != 32'd0) ? eff_stack + STACK_SPAN
                                                               : 32'd0;
            end else begin
               rsp_in.resume_sp = req_ff.saved_sp;
            end
         end
         rrtt_pkg::CMD_CREATE: begin
            if (used_ff[ptr_ff]) begin
               rsp_in.status = rrtt_pkg::ST_NO_SLOT;
            end else if (req_ff.stack_addr == 32'd0 || req_ff.dir_addr == 32'd0) begin
               rsp_in.status = rrtt_pkg::ST_ALLOC_FAIL;
            end else begin
               create_ok               = 1'b1;
               used_in[ptr_ff]         = 1'b1;
               cnt_in                  = cnt_ff + 1'b1;
               if (HW'(ptr_ff) >= hw_ff) begin
                  hw_in = HW'(ptr_ff) + 1'b1;
               end
               rsp_in.slot             = slot3(ptr_ff);
               rsp_in.resume_sp        = new_sp;
               rsp_in.kernel_stack_top = top_ff;
            end
         end
         rrtt_pkg::CMD_EXIT: begin
            last_in     = req_ff.exit_code;
            rsp_in.slot = slot3(run_ff);
            if (used_ff[run_ff]) begin
               rsp_in.release_stack = eff_stack;
               if (eff_dir != 32'd0 && eff_dir != kdir_ff) begin
                  rsp_in.release_dir = eff_dir;
               end
               used_in[run_ff] = 1'b0;
               cnt_in          = cnt_ff - 1'b1;
               if (run_ff == '0) begin
                  boot_in = 1'b0;
               end
            end
         end
         rrtt_pkg::CMD_NONE: begin
            rsp_in.slot = slot3(run_ff);
         end
      endcase
      // all used slots sit below the high-water mark
      rsp_in.others_ready  = (cnt_in > HW'(used_in[run_in]));
      rsp_in.recorded_code = last_in;
   end

   // Stack pointer RAM writes: schedule saves at capture, create at finish
   always_comb begin
      if (ctl.capture) begin
         sp_we    = (new_cmd == rrtt_pkg::CMD_SCHEDULE);
         sp_waddr = run_ff;
         sp_wdata = req_word.saved_sp;
      end else begin
         sp_we    = ctl.finish && create_ok;
         sp_waddr = ptr_ff;
         sp_wdata = new_sp;
      end
      ctx_we = ctl.finish && create_ok;
   end

   rrtt_ram #(
      .WIDTH (32),
      .DEPTH (SLOTS)
   ) u_sp_ram (
      .clock   (clock),
      .wr_en   (sp_we),
      .wr_addr (sp_waddr),
      .wr_data (sp_wdata),
      .rd_addr (rd_addr),
      .rd_data (sp_rd)
   );

   rrtt_ram #(
      .WIDTH (64),
      .DEPTH (SLOTS)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ctx_we),
      .wr_addr (ptr_ff),
      .wr_data ({req_ff.stack_addr, req_ff.dir_addr}),
      .rd_addr (rd_addr),
      .rd_data (ctx_rd)
   );

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= SLOTS'(1);
         cnt_ff  <= HW'(1);
         run_ff  <= '0;
         hw_ff   <= HW'(1);
         boot_ff <= 1'b1;
         last_ff <= '0;
         kdir_ff <= '0;
      end else begin
         if (ctl.finish) begin
            used_ff <= used_in;
            cnt_ff  <= cnt_in;
            run_ff  <= run_in;
            hw_ff   <= hw_in;
            boot_ff <= boot_in;
            last_ff <= last_in;
         end
         if (csr_we) begin
            kdir_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_word;
      end
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff <= ptr_in;
      top_ff <= req_ff.stack_addr + STACK_SPAN;
   end

   assign rsp_word = rsp_ff;

endmodule

@@ rtl/round_robin_task_table.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_table
// Task slot table with round-robin dispatch: create, schedule and exit
// commands over SLOTS slots, one response word per command.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; exactly one
// response word follows on rsp_word, marked by rsp_strobe for one cycle, and
// it must be taken in that cycle. Busy stays high from the accepting edge
// until the response is loaded. The slot scan tests one slot per cycle: a
// schedule scans from the slot after the running one, wrapping below the
// high-water mark, and reads the table when it moves to another slot; a
// create scans up from slot zero to the lowest free slot, or to the last
// slot when the table is full. A new command may be started in the cycle
// the response is strobed. csr_wdata loads the kernel page directory and
// should only be written while no command is in flight.
// ----------------------------------------------------------------------------
module round_robin_task_table #(
   parameter int SLOTS       = 8,
   parameter int STACK_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrtt_pkg::req_type req_word,
   output logic              rsp_strobe,
   output rrtt_pkg::rsp_type rsp_word,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   rrtt_pkg::ctl_type ctl;
   rrtt_pkg::sts_type sts;

   // Sequencer
   rrtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .command    (req_word.command),
      .sts        (sts),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Table and response datapath
   rrtt_dpath #(
      .SLOTS       (SLOTS),
      .STACK_BYTES (STACK_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_word  (rsp_word)
   );

endmodule

@@ rtl/rrtt_checker.sv @@
// ----------------------------------------------------------------------------
// rrtt_checker
// Port-level checks for the task table, bound to the top level.
// ----------------------------------------------------------------------------
module rrtt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input rrtt_pkg::rsp_type rsp_word,
   input logic              rsp_strobe
);

   // Every accepted command raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // A response word only appears once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobed while busy");

   // One word per command: strobes never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobed twice in a row");

   // A failed create carries no dispatch information
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status != rrtt_pkg::ST_OK |->
         !rsp_word.switched && rsp_word.resume_sp == 32'd0 &&
         rsp_word.kernel_stack_top == 32'd0)
      else $error("failed create returned dispatch data");

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_word   (rsp_word),
   .rsp_strobe (rsp_strobe)
);

@@ dv/tb_round_robin_task_table.sv @@
// ----------------------------------------------------------------------------
// tb_round_robin_task_table
// Self-checking bench for the task slot table. Command words go in through
// the start/busy handshake, directed and in random bursts; a local copy of the slot table
// predicts every response word, which is checked field by field as it is
// strobed out. The kernel directory register is reloaded between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_round_robin_task_table;

   localparam int          SLOTS       = 8;
   localparam logic [31:0] STACK_BYTES = 32'd4096;
   localparam int          SETTLE      = 20;    // quiet cycles after the last response
   localparam int          STALL_LIMIT = 2000;  // cycles with no handshake before giving up

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   logic              busy;
   rrtt_pkg::req_type req_word   = '0;
   logic              rsp_strobe;
   rrtt_pkg::rsp_type rsp_word;
   logic              csr_we     = 1'b0;
   logic [31:0]       csr_wdata  = '0;

   int          errors      = 0;
   int          idle_cycles = 0;

   // Predicted response words, oldest first
   rrtt_pkg::rsp_type sched_rsp_q[$];
   rrtt_pkg::rsp_type want_rsp;

   // Shadow copy of the slot table
   bit          slot_live [SLOTS];
   logic [31:0] sp_tab    [SLOTS];
   logic [31:0] stk_tab   [SLOTS];
   logic [31:0] dir_tab   [SLOTS];
   int          cur_slot;
   int          high_mark;
   logic [31:0] last_code;
   logic [31:0] kdir;

   round_robin_task_table #(
      .SLOTS       (SLOTS),
      .STACK_BYTES (4096)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Slot table shadow
   // ------------------------------------------------------------------------
   task automatic table_reset();
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         sp_tab[i]    = '0;
         stk_tab[i]   = '0;
         dir_tab[i]   = '0;
      end
      kdir         = '0;
      slot_live[0] = 1'b1;   // boot task
      dir_tab[0]   = kdir;
      cur_slot     = 0;
      high_mark    = 1;
      last_code    = '0;
   endtask

   // Apply one command word to the shadow table and return its response
   function automatic rrtt_pkg::rsp_type table_response(input rrtt_pkg::req_type w);
      rrtt_pkg::rsp_type r;
      int      prev;
      int      nxt;
      int      id;
      r = '0;
      unique case (rrtt_pkg::cmd_type'(w.command))
         rrtt_pkg::CMD_SCHEDULE: begin
            prev = cur_slot;
            nxt  = prev;
            sp_tab[prev] = w.saved_sp;
            // round-robin scan below the high-water mark; lands back on prev if none
            for (int i = 0; i < high_mark; i++) begin
               nxt = (nxt + 1) % high_mark;
               if (slot_live[nxt]) break;
            end
            cur_slot    = nxt;
            r.slot      = 3'(nxt);
            r.resume_sp = sp_tab[nxt];
            if (nxt != prev) begin
               r.switched         = 1'b1;
               r.next_dir         = dir_tab[nxt];
               r.kernel_stack_top = (stk_tab[nxt] != 0) ? stk_tab[nxt] + STACK_BYTES : 32'd0;
            end
         end
         rrtt_pkg::CMD_CREATE: begin
            id = SLOTS;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!slot_live[i]) id = i;
            if (id == SLOTS) begin
               r.status = rrtt_pkg::ST_NO_SLOT;
            end else if (w.stack_addr == 0 || w.dir_addr == 0) begin
               r.status = rrtt_pkg::ST_ALLOC_FAIL;
            end else begin
               // saved sp sits one frame below the top; top wraps at 2^32
               sp_tab[id]    = w.stack_addr + STACK_BYTES -
                               (w.user_task ? rrtt_pkg::USER_FRAME_BYTES
                                            : rrtt_pkg::KERNEL_FRAME_BYTES);
               stk_tab[id]   = w.stack_addr;
               dir_tab[id]   = w.dir_addr;
               slot_live[id] = 1'b1;
               if (id >= high_mark) high_mark = id + 1;
               r.slot             = 3'(id);
               r.resume_sp        = sp_tab[id];
               r.kernel_stack_top = w.stack_addr + STACK_BYTES;
            end
         end
         rrtt_pkg::CMD_EXIT: begin
            id        = cur_slot;
            last_code = w.exit_code;
            // a slot already freed releases nothing
            if (slot_live[id]) begin
               r.release_stack = stk_tab[id];
               if (dir_tab[id] != 0 && dir_tab[id] != kdir) r.release_dir = dir_tab[id];
               stk_tab[id]   = '0;
               dir_tab[id]   = '0;
               slot_live[id] = 1'b0;
            end
            r.slot = 3'(id);
         end
         default: begin
            r.slot = 3'(cur_slot);
         end
      endcase
      for (int i = 0; i < high_mark; i++)
         if (i != cur_slot && slot_live[i]) r.others_ready = 1'b1;
      r.recorded_code = last_code;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic rrtt_pkg::req_type cmd_word(rrtt_pkg::cmd_type c,
                                                  logic [31:0] sp, stk, dir,
                                                  logic user, logic [31:0] code);
      rrtt_pkg::req_type w;
      w.command    = c;
      w.saved_sp   = sp;
      w.stack_addr = stk;
      w.dir_addr   = dir;
      w.user_task  = user;
      w.exit_code  = code;
      return w;
   endfunction

   // Hold the word on the port until the block takes it, then predict
   task automatic send_item(input rrtt_pkg::req_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sched_rsp_q.push_back(table_response(w));
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending and let every outstanding response come back
   task automatic drain_table();
      start <= 1'b0;
      while (sched_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes only while the table is idle
   task automatic load_kernel_dir(input logic [31:0] v);
      drain_table();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      kdir = v;
      if (slot_live[0] && stk_tab[0] == 0) dir_tab[0] = v;  // boot task follows the register
   endtask

   // Mostly well-formed traffic: schedules, creates with good addresses, exits
   function automatic rrtt_pkg::req_type rand_word();
      rrtt_pkg::req_type w;
      int      pick;
      w.command    = rrtt_pkg::CMD_SCHEDULE;
      w.saved_sp   = $urandom;
      w.stack_addr = $urandom;
      w.dir_addr   = $urandom;
      w.user_task  = 1'($urandom_range(0, 1));
      w.exit_code  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 44)      w.command = rrtt_pkg::CMD_SCHEDULE;
      else if (pick < 74) w.command = rrtt_pkg::CMD_CREATE;
      else if (pick < 95) w.command = rrtt_pkg::CMD_EXIT;
      else                w.command = rrtt_pkg::CMD_NONE;
      pick = $urandom_range(0, 19);
      if (pick == 0)      w.stack_addr = '0;
      else if (pick == 1) w.stack_addr = 32'hFFFF_F000 | 32'($urandom_range(0, 4095));
      pick = $urandom_range(0, 19);
      if (pick == 0)      w.dir_addr = '0;
      else if (pick < 3)  w.dir_addr = kdir;
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Boot task alone: directory follows the register, schedule stays put
   task automatic test_boot_task();
      load_kernel_dir(32'hFFFF_FFFF);
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_NONE, '1, '1, '1, 1'b1, '1));
   endtask

   // Allocation failures, stack wrap, both frame sizes
   task automatic test_create_checks();
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, '0, 32'h0000_2000, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'h0001_0000, '0, 1'b1, '0));
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'hFFFF_F000, 32'h0000_1000, 1'b0,
                         '0));
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1,
                         '0));
   endtask

   // Round-robin order across the created slots, then fill the table
   task automatic test_dispatch_order();
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, '0, '0, '0, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'h1234_5678, '0, '0, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'h8000_0000, '0, '0, 1'b0, '0));
      for (int i = 3; i < SLOTS; i++)
         send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'h0010_0000 * i,
                            32'h0200_0000 + i, 1'(i), '0));
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'h0A00_0000, 32'h0B00_0000, 1'b0,
                         '0));
   endtask

   // Exits: boot task, a freed slot, a private directory, the kernel directory
   task automatic test_exit_release();
      send_item(cmd_word(rrtt_pkg::CMD_EXIT, '0, '0, '0, 1'b0, 32'h8000_0000));
      send_item(cmd_word(rrtt_pkg::CMD_EXIT, '0, '0, '0, 1'b0, 32'h7FFF_FFFF));
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'h0000_0040, '0, '0, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_EXIT, '0, '0, '0, 1'b0, 32'hFFFF_FFFF));
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'h0000_0080, '0, '0, 1'b0, '0));
      send_item(cmd_word(rrtt_pkg::CMD_EXIT, '0, '0, '0, 1'b0, '0));
      load_kernel_dir(32'h0000_0000);
      send_item(cmd_word(rrtt_pkg::CMD_CREATE, '0, 32'h0300_0000, 32'h0400_0000, 1'b1,
                         '0));
      send_item(cmd_word(rrtt_pkg::CMD_SCHEDULE, 32'hDEAD_BEEF, '0, '0, 1'b0, '0));
   endtask

   // Random bursts with random gaps, some bursts back to back
   task automatic test_random_traffic(input int n_items);
      int sent;
      int burst;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         repeat (burst) send_item(rand_word());
         sent += burst;
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 14));
      end
   endtask

   // ------------------------------------------------------------------------
   // Response check
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (sched_rsp_q.size() == 0) begin
            $display("%0t: unexpected response word: expected none, actual %h",
                     $time, rsp_word);
            errors++;
         end else begin
            want_rsp = sched_rsp_q.pop_front();
            check_field("status",           32'(want_rsp.status),
                        32'(rsp_word.status));
            check_field("slot",             32'(want_rsp.slot),
                        32'(rsp_word.slot));
            check_field("resume_sp",        want_rsp.resume_sp,        rsp_word.resume_sp);
            check_field("switched",         32'(want_rsp.switched),
                        32'(rsp_word.switched));
            check_field("next_dir",         want_rsp.next_dir,         rsp_word.next_dir);
            check_field("kernel_stack_top", want_rsp.kernel_stack_top,
                        rsp_word.kernel_stack_top);
            check_field("release_stack",    want_rsp.release_stack,    rsp_word.release_stack);
            check_field("release_dir",      want_rsp.release_dir,      rsp_word.release_dir);
            check_field("others_ready",     32'(want_rsp.others_ready),
                        32'(rsp_word.others_ready));
            check_field("recorded_code",    want_rsp.recorded_code,    rsp_word.recorded_code);
         end
      end
   end

   // Watchdog: no accepted command and no response for too long
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("round_robin_task_table regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      table_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_boot_task();
      test_create_checks();
      test_dispatch_order();
      test_exit_release();

      load_kernel_dir($urandom);
      test_random_traffic(380);
      load_kernel_dir(32'h0000_0000);
      test_random_traffic(380);
      load_kernel_dir(32'hFFFF_FFFF);
      test_random_traffic(380);
      load_kernel_dir($urandom);
      test_random_traffic(380);

      drain_table();
      if (errors == 0) begin
         $display("round_robin_task_table regression: pass");
      end else begin
         $display("round_robin_task_table regression: fail");
      end
      $finish;
   end

endmodule
